// File: sv/rc_pulse_to_stepper_steering_macros.svh
// ---------------------------------------------------------------------------
// RC steering assertion macros
// Shared concurrent assertion forms for the steering block.
// ---------------------------------------------------------------------------
`ifndef RC_PULSE_TO_STEPPER_STEERING_MACROS_SVH
`define RC_PULSE_TO_STEPPER_STEERING_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcs assertion failed");

// next-cycle implication, disabled in reset
`define RCS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcs assertion failed");

`endif

// File: sv/rcs_pkg.sv
// ---------------------------------------------------------------------------
// rcs_pkg
// Types, widths and codes shared by the RC steering controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int FRAC_BITS = 8;
    localparam int PW_BITS   = 12;

    localparam int CTR_W = 12;
    localparam int DB_W  = 8;
    localparam int ANG_W = 8;
    localparam int PPD_W = 11;
    localparam int VEL_W = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int POS_W   = 19;
    localparam int DELTA_W = 20;
    localparam int POS_MAX = 2 ** (POS_W - 1) - 1;

    localparam int OFF_W     = (PW_BITS > CTR_W) ? PW_BITS : CTR_W;
    localparam int CMP_W     = OFF_W + 2;
    localparam int AMAX_W    = ANG_W + FRAC_BITS;
    localparam int PROD_W    = OFF_W + AMAX_W;
    localparam int CUR_MAG_W = POS_W + FRAC_BITS;
    localparam int CUR_W     = CUR_MAG_W + 1;
    localparam int TGT_W     = AMAX_W + 1;
    localparam int TPP_W     = TGT_W + PPD_W + 1;

    localparam int DIV_W = 2 * ((PROD_W + 3) / 2);
    localparam int DEN_W = CTR_W + 1;
    localparam int ITER  = DIV_W / 2;
    localparam int CNT_W = $clog2(ITER);

    localparam int TENTH        = (2 ** (FRAC_BITS + 1) + 10) / 20;
    localparam int SMALL_PULSES = 5;

    localparam int IN_PAY_W    = PW_BITS + 3;
    localparam int IN_TDATA_W  = 8 * ((IN_PAY_W + 7) / 8);
    localparam int OUT_PAY_W   = DELTA_W + VEL_W + 2 + POS_W;
    localparam int OUT_TDATA_W = 8 * ((OUT_PAY_W + 7) / 8);
    localparam int TUSER_W     = 2;

    localparam int RST_CENTER   = 1500;
    localparam int RST_DEADBAND = 20;
    localparam int RST_MIN      = 1000;
    localparam int RST_MAX      = 2000;
    localparam int RST_ANGLE    = 30;
    localparam int RST_PPD      = 100;
    localparam int RST_VEL      = 4000;

    typedef enum logic [1:0] {
        OP_PULSE      = 2'd0,
        OP_STOP       = 2'd1,
        OP_LEFT_EDGE  = 2'd2,
        OP_RIGHT_EDGE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_MOVE      = 2'd1,
        CMD_STOP      = 2'd2,
        CMD_FAST_STOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_LEFT   = 2'd2,
        MODE_RIGHT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER    = 3'd0,
        CFG_DEADBAND  = 3'd1,
        CFG_MIN_VALID = 3'd2,
        CFG_MAX_VALID = 3'd3,
        CFG_MAX_ANGLE = 3'd4,
        CFG_PPD       = 3'd5,
        CFG_VELOCITY  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUR_START,
        ST_CUR_WAIT,
        ST_MUL,
        ST_TGT_START,
        ST_TGT_WAIT,
        ST_TGT_LOAD,
        ST_BLOCK,
        ST_TP_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic cur_start;
        logic cur_load;
        logic mul;
        logic tgt_start;
        logic tgt_load;
        logic block;
        logic tp_load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_pulse;
        logic div_done;
        logic need_div;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/rcs_div.sv
// ---------------------------------------------------------------------------
// rcs_div
// Unsigned restoring divider, two quotient bits per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rcs_pkg::DIV_W-1:0]  i_num,
    input  logic [rcs_pkg::DEN_W-1:0]  i_den,
    output logic [rcs_pkg::DIV_W-1:0]  o_quo,
    output logic                       o_done
);
    import rcs_pkg::*;

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    always_comb begin
        logic [DEN_W:0]   sh;
        logic [DEN_W-1:0] rem;
        logic [DIV_W-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            sh  = {rem, quo[DIV_W-1]};
            quo = {quo[DIV_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh     = sh - {1'b0, r_den};
                quo[0] = 1'b1;
            end
            rem = sh[DEN_W-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// File: sv/rcs_dp.sv
// ---------------------------------------------------------------------------
// rcs_dp
// Steering datapath: config registers, position/mode state, target math.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc_pulse_to_stepper_steering_macros.svh"

module rcs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [rcs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                      i_in_op,
    input  logic [rcs_pkg::PW_BITS-1:0]     i_in_pulse,
    input  logic                            i_in_lt,
    input  logic                            i_in_rt,
    input  logic                            i_in_run,
    input  rcs_pkg::t_dp_cmd                i_cmd,
    output rcs_pkg::t_dp_sts                o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output rcs_pkg::t_cmd                   o_out_cmd,
    output logic [rcs_pkg::DELTA_W-1:0]     o_out_delta,
    output logic [rcs_pkg::VEL_W-1:0]       o_out_vel,
    output rcs_pkg::t_mode                  o_out_mode,
    output logic [rcs_pkg::POS_W-1:0]       o_out_pos
);
    import rcs_pkg::*;

    localparam logic signed [POS_W-1:0]   POS_MAX_S = POS_W'(POS_MAX);
    localparam logic signed [DELTA_W-1:0] SMALL_S   = DELTA_W'(SMALL_PULSES);
    localparam logic [TPP_W:0]            HALF_LSB  = (TPP_W+1)'(2 ** (FRAC_BITS - 1));

    // config
    logic [CTR_W-1:0] r_center, r_min, r_max;
    logic [DB_W-1:0]  r_deadband;
    logic [ANG_W-1:0] r_angle;
    logic [PPD_W-1:0] r_ppd;
    logic [VEL_W-1:0] r_vel;

    // state
    logic signed [POS_W-1:0] r_pos;
    t_mode                   r_mode;

    // captured item
    t_op                  r_op;
    logic [PW_BITS-1:0]   r_pulse;
    logic                 r_lt, r_rt, r_run;

    // working registers
    logic signed [CUR_W-1:0] r_cur;
    logic [PROD_W-1:0]       r_prod;
    logic signed [TGT_W-1:0] r_tgt;
    logic                    r_hold0, r_hold;
    t_mode                   r_mode0, r_mode1;
    logic                    r_dg_small;
    logic signed [TPP_W-1:0] r_tpp;
    logic signed [POS_W-1:0] r_tp;

    // output register
    logic                    r_out_valid;
    t_cmd                    r_out_cmd;
    logic signed [DELTA_W-1:0] r_out_delta;
    logic [VEL_W-1:0]        r_out_vel;
    t_mode                   r_out_mode;
    logic signed [POS_W-1:0] r_out_pos;

    // divider hookup
    logic [DIV_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic             div_start, div_done;

    // decode
    logic signed [CMP_W-1:0] c_s, d_s, p_s, span_l, span_r, span_sel;
    logic                    below, above, move_l, move_r, need_div;
    logic [OFF_W-1:0]        offset;
    logic [CTR_W-1:0]        span_u;
    logic [AMAX_W-1:0]       amax;
    logic [PPD_W-1:0]        ppd_eff;
    logic [POS_W-1:0]        pos_abs;
    logic [DIV_W-1:0]        num_cur, num_tgt;
    logic [DEN_W-1:0]        den_cur, den_tgt;

    always_comb begin
        c_s    = signed'(CMP_W'(r_center));
        d_s    = signed'(CMP_W'(r_deadband));
        p_s    = signed'(CMP_W'(r_pulse));
        below  = p_s < (c_s - d_s);
        above  = p_s > (c_s + d_s);
        span_l = c_s - signed'(CMP_W'(r_min));
        span_r = signed'(CMP_W'(r_max)) - c_s;
        move_l = below && !r_lt;
        move_r = above && !r_rt;
        need_div = (move_l && (span_l > 0)) || (move_r && (span_r > 0));
        span_sel = move_l ? span_l : span_r;
        span_u   = span_sel[CTR_W-1:0];
        offset   = below ? OFF_W'(c_s - p_s) : OFF_W'(p_s - c_s);
        amax     = {r_angle, {FRAC_BITS{1'b0}}};
        ppd_eff  = (r_ppd == '0) ? PPD_W'(1) : r_ppd;
        pos_abs  = r_pos[POS_W-1] ? POS_W'(-r_pos) : POS_W'(r_pos);
        // rounded division: (2a + den) / (2 den)
        num_cur  = (DIV_W'(pos_abs) << (FRAC_BITS + 1)) + DIV_W'(ppd_eff);
        den_cur  = DEN_W'({ppd_eff, 1'b0});
        num_tgt  = (DIV_W'(r_prod) << 1) + DIV_W'(span_u);
        den_tgt  = DEN_W'({span_u, 1'b0});
    end

    assign div_start = i_cmd.cur_start | i_cmd.tgt_start;
    assign div_num   = i_cmd.tgt_start ? num_tgt : num_cur;
    assign div_den   = i_cmd.tgt_start ? den_tgt : den_cur;

    rcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // target angle after saturation
    logic signed [CUR_W-1:0] amax_c;
    logic [AMAX_W-1:0]       q_min, mag_sel;
    logic signed [TGT_W-1:0] cur_clamp, tgt_n;
    logic signed [CUR_W-1:0] q_cur;
    t_mode                   mode0_n;

    always_comb begin
        amax_c  = signed'(CUR_W'(amax));
        q_cur   = signed'(CUR_W'(div_quo));
        q_min   = (div_quo > DIV_W'(amax)) ? amax : div_quo[AMAX_W-1:0];
        mag_sel = need_div ? q_min : amax;
        if (r_cur > amax_c) begin
            cur_clamp = signed'(TGT_W'(amax));
        end else if (r_cur < -amax_c) begin
            cur_clamp = -signed'(TGT_W'(amax));
        end else begin
            cur_clamp = TGT_W'(r_cur);
        end
        priority if (move_l) begin
            tgt_n = -signed'(TGT_W'(mag_sel));
        end else if (move_r) begin
            tgt_n = signed'(TGT_W'(mag_sel));
        end else begin
            tgt_n = cur_clamp;
        end
        priority if (below || above) begin
            mode0_n = MODE_MOVING;
        end else if (!r_run) begin
            mode0_n = MODE_IDLE;
        end else begin
            mode0_n = r_mode;
        end
    end

    // limit blocking and small-angle check
    logic signed [CUR_W-1:0] tgt_ext;
    logic signed [CUR_W:0]   dg;
    logic [CUR_W:0]          dg_abs;
    logic                    lt_blk, rt_blk;

    always_comb begin
        tgt_ext = CUR_W'(r_tgt);
        lt_blk  = r_lt && (tgt_ext < r_cur);
        rt_blk  = !lt_blk && r_rt && (tgt_ext > r_cur);
        dg      = (CUR_W+1)'(tgt_ext) - (CUR_W+1)'(r_cur);
        dg_abs  = dg[CUR_W] ? (CUR_W+1)'(-dg) : (CUR_W+1)'(dg);
    end

    // tp = round(tgt * ppd / 2^FRAC_BITS), saturated
    logic [TPP_W-1:0]        tpp_abs;
    logic [TPP_W:0]          tp_mag;
    logic signed [POS_W-1:0] tp_sat;

    always_comb begin
        tpp_abs = r_tpp[TPP_W-1] ? TPP_W'(-r_tpp) : TPP_W'(r_tpp);
        tp_mag  = ({1'b0, tpp_abs} + HALF_LSB) >> FRAC_BITS;
        tp_sat  = (tp_mag > (TPP_W+1)'(POS_MAX)) ? POS_MAX_S : signed'(POS_W'(tp_mag));
    end

    // final decision
    logic signed [DELTA_W-1:0] delta;
    logic                      ad_small, do_move;

    always_comb begin
        delta    = DELTA_W'(r_tp) - DELTA_W'(r_pos);
        ad_small = (delta > -SMALL_S) && (delta < SMALL_S);
        do_move  = (delta != '0) && !(ad_small && r_dg_small);
    end

    // control state, config, position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= CTR_W'(RST_CENTER);
            r_deadband  <= DB_W'(RST_DEADBAND);
            r_min       <= CTR_W'(RST_MIN);
            r_max       <= CTR_W'(RST_MAX);
            r_angle     <= ANG_W'(RST_ANGLE);
            r_ppd       <= PPD_W'(RST_PPD);
            r_vel       <= VEL_W'(RST_VEL);
            r_pos       <= '0;
            r_mode      <= MODE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_CENTER:    r_center   <= i_cfg_data[CTR_W-1:0];
                    CFG_DEADBAND:  r_deadband <= i_cfg_data[DB_W-1:0];
                    CFG_MIN_VALID: r_min      <= i_cfg_data[CTR_W-1:0];
                    CFG_MAX_VALID: r_max      <= i_cfg_data[CTR_W-1:0];
                    CFG_MAX_ANGLE: r_angle    <= i_cfg_data[ANG_W-1:0];
                    CFG_PPD:       r_ppd      <= i_cfg_data[PPD_W-1:0];
                    CFG_VELOCITY:  r_vel      <= i_cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                unique case (r_op)
                    OP_STOP:       r_mode <= MODE_IDLE;
                    OP_LEFT_EDGE:  r_mode <= MODE_LEFT;
                    OP_RIGHT_EDGE: r_mode <= MODE_RIGHT;
                    OP_PULSE: begin
                        r_mode <= r_mode1;
                        if (do_move) begin
                            r_pos <= r_tp;
                        end
                    end
                    default: ;
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_in_op);
            r_pulse <= i_in_pulse;
            r_lt    <= i_in_lt;
            r_rt    <= i_in_rt;
            r_run   <= i_in_run;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_pos[POS_W-1] ? -q_cur : q_cur;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(offset) * PROD_W'(amax);
        end
        if (i_cmd.tgt_load) begin
            r_tgt   <= tgt_n;
            r_hold0 <= !(move_l || move_r);
            r_mode0 <= mode0_n;
        end
        if (i_cmd.block) begin
            r_tpp      <= TPP_W'(r_tgt) * signed'(TPP_W'(ppd_eff));
            r_hold     <= r_hold0 || lt_blk || rt_blk;
            r_mode1    <= lt_blk ? MODE_LEFT : (rt_blk ? MODE_RIGHT : r_mode0);
            r_dg_small <= lt_blk || rt_blk || (dg_abs < (CUR_W+1)'(TENTH));
        end
        if (i_cmd.tp_load) begin
            r_tp <= r_hold ? r_pos : (r_tpp[TPP_W-1] ? -tp_sat : tp_sat);
        end
        if (i_cmd.emit) begin
            unique case (r_op)
                OP_STOP: begin
                    r_out_cmd   <= CMD_STOP;
                    r_out_delta <= '0;
                    r_out_vel   <= '0;
                    r_out_mode  <= MODE_IDLE;
                end
                OP_LEFT_EDGE: begin
                    r_out_cmd   <= CMD_FAST_STOP;
                    r_out_delta <= '0;
                    r_out_vel   <= '0;
                    r_out_mode  <= MODE_LEFT;
                end
                OP_RIGHT_EDGE: begin
                    r_out_cmd   <= CMD_FAST_STOP;
                    r_out_delta <= '0;
                    r_out_vel   <= '0;
                    r_out_mode  <= MODE_RIGHT;
                end
                default: begin
                    r_out_cmd   <= do_move ? CMD_MOVE : CMD_NONE;
                    r_out_delta <= do_move ? delta : '0;
                    r_out_vel   <= do_move ? r_vel : '0;
                    r_out_mode  <= r_mode1;
                end
            endcase
            r_out_pos <= (r_op == OP_PULSE && do_move) ? r_tp : r_pos;
        end
    end

    assign o_sts.in_pulse = (t_op'(i_in_op) == OP_PULSE);
    assign o_sts.div_done = div_done;
    assign o_sts.need_div = need_div;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_cmd   = r_out_cmd;
    assign o_out_delta = r_out_delta;
    assign o_out_vel   = r_out_vel;
    assign o_out_mode  = r_out_mode;
    assign o_out_pos   = r_out_pos;

    `RCS_ASSERT_IMPL(a_move_has_delta, i_clk, i_rst_n, r_out_valid && (r_out_cmd == CMD_MOVE), r_out_delta != '0)
    `RCS_ASSERT_IMPL(a_other_no_motion, i_clk, i_rst_n, r_out_valid && (r_out_cmd != CMD_MOVE), (r_out_delta == '0) && (r_out_vel == '0))
    `RCS_ASSERT_IMPL(a_pos_in_range, i_clk, i_rst_n, 1'b1, (r_pos <= POS_MAX_S) && (r_pos >= -POS_MAX_S))
    `RCS_ASSERT_NEXT(a_emit_shows_pos, i_clk, i_rst_n, i_cmd.emit, r_out_valid && (r_out_pos == r_pos))
    `RCS_ASSERT_NEXT(a_pos_only_on_emit, i_clk, i_rst_n, !i_cmd.emit, $stable(r_pos))

endmodule

// File: sv/rcs_ctrl.sv
// ---------------------------------------------------------------------------
// rcs_ctrl
// Sequencer for the steering datapath: capture, divide, scale, emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rcs_pkg::t_dp_sts  i_sts,
    output rcs_pkg::t_dp_cmd  o_cmd
);
    import rcs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_pulse ? ST_CUR_START : ST_EMIT;
                end
            end
            ST_CUR_START: n_state = ST_CUR_WAIT;
            ST_CUR_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:       n_state = i_sts.need_div ? ST_TGT_START : ST_TGT_LOAD;
            ST_TGT_START: n_state = ST_TGT_WAIT;
            ST_TGT_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_TGT_LOAD;
                end
            end
            ST_TGT_LOAD:  n_state = ST_BLOCK;
            ST_BLOCK:     n_state = ST_TP_LOAD;
            ST_TP_LOAD:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_CUR_START: o_cmd.cur_start = 1'b1;
            ST_CUR_WAIT:  o_cmd.cur_load  = i_sts.div_done;
            ST_MUL:       o_cmd.mul       = 1'b1;
            ST_TGT_START: o_cmd.tgt_start = 1'b1;
            ST_TGT_WAIT:  ;
            ST_TGT_LOAD:  o_cmd.tgt_load  = 1'b1;
            ST_BLOCK:     o_cmd.block     = 1'b1;
            ST_TP_LOAD:   o_cmd.tp_load   = 1'b1;
            ST_EMIT:      o_cmd.emit      = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// File: sv/rc_pulse_to_stepper_steering.sv
// A pulse update makes one pass through the shared divider for the current angle and,
// when the target needs it, a second pass for the target angle, then scales the result.
// Stop and limit-edge items skip these steps and go straight to the emit state. Input
// ready returns in the idle state after the emit state loads the output register,
// one item in flight at a time. Reset is synchronous, active low: config registers
// return to their defaults, position 0, mode idle, output empty. No clearing pass.
// ---------------------------------------------------------------------------
// rc_pulse_to_stepper_steering
// RC pulse width to stepper steering command, with limits and small-move skip.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc_pulse_to_stepper_steering (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rcs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pulse_width[11:0], limit_left[12], limit_right[13], generator_running[14]
    input  logic [rcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op[1:0]
    input  logic [rcs_pkg::TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // move_delta_pulses[19:0], velocity_pps[35:20], steer_mode[37:36],
    // position_now[56:38]
    output logic [rcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // command[1:0]
    output logic [rcs_pkg::TUSER_W-1:0]       m_axis_tuser
);
    import rcs_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    t_cmd                 out_cmd;
    t_mode                out_mode;
    logic [DELTA_W-1:0]   out_delta;
    logic [VEL_W-1:0]     out_vel;
    logic [POS_W-1:0]     out_pos;

    assign o_cfg_ready = 1'b1;

    rcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    rcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_op     (s_axis_tuser),
        .i_in_pulse  (s_axis_tdata[PW_BITS-1:0]),
        .i_in_lt     (s_axis_tdata[PW_BITS]),
        .i_in_rt     (s_axis_tdata[PW_BITS+1]),
        .i_in_run    (s_axis_tdata[PW_BITS+2]),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_cmd   (out_cmd),
        .o_out_delta (out_delta),
        .o_out_vel   (out_vel),
        .o_out_mode  (out_mode),
        .o_out_pos   (out_pos)
    );

    assign m_axis_tuser = TUSER_W'(out_cmd);
    assign m_axis_tdata = OUT_TDATA_W'({out_pos, out_mode, out_vel, out_delta});

endmodule

// File: tb/sv/steering_checker.sv
// ---------------------------------------------------------------------------
// steering_checker
// Watches the register, input and result channels of the RC steering block,
// keeps its own copy of position, mode and registers, predicts the command
// for every input transaction and compares each result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module steering_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [rcs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [rcs_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  logic [rcs_pkg::TUSER_W-1:0]        i_in_user,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [rcs_pkg::OUT_TDATA_W-1:0]    i_out_data,
    input  logic [rcs_pkg::TUSER_W-1:0]        i_out_user,
    input  logic                               i_end_check,
    output int                                 o_pending,
    output int                                 o_errors
);
    import rcs_pkg::*;

    typedef struct packed {
        t_cmd               cmd;
        logic [DELTA_W-1:0] delta;
        logic [VEL_W-1:0]   vel;
        t_mode              mode;
        logic [POS_W-1:0]   pos;
    } t_steer_result;

    t_steer_result expected_commands[$];

    longint center_cfg, deadband_cfg, min_cfg, max_cfg, angle_cfg, ppd_cfg, vel_cfg;
    longint pos_q;
    t_mode  mode_q;
    int     errs;
    int     results_seen;
    bit     end_done;

    // quotient rounded half away from zero, den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint a;
        longint q;
        a = (num < 0) ? -num : num;
        q = (2 * a + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_steer_result predict_steering(input t_op op, input logic [PW_BITS-1:0] pw,
                                                       input logic lt, input logic rt,
                                                       input logic running);
        t_steer_result r;
        longint one, ppd, amax, p, cur, tgt, span, tp, delta, tenth, ad, dg;
        bit     hold;
        r.cmd   = CMD_NONE;
        r.delta = '0;
        r.vel   = '0;
        case (op)
            OP_STOP: begin
                r.cmd  = CMD_STOP;
                mode_q = MODE_IDLE;
            end
            OP_LEFT_EDGE: begin
                r.cmd  = CMD_FAST_STOP;
                mode_q = MODE_LEFT;
            end
            OP_RIGHT_EDGE: begin
                r.cmd  = CMD_FAST_STOP;
                mode_q = MODE_RIGHT;
            end
            default: begin
                one  = longint'(1) << FRAC_BITS;
                ppd  = (ppd_cfg == 0) ? 1 : ppd_cfg;
                amax = angle_cfg * one;
                p    = longint'(pw);
                cur  = round_div(pos_q * one, ppd);
                tgt  = cur;
                hold = 1'b1;
                if (p < center_cfg - deadband_cfg) begin
                    span = center_cfg - min_cfg;
                    if (!lt) begin
                        tgt  = (span > 0) ? -round_div((center_cfg - p) * amax, span) : -amax;
                        hold = 1'b0;
                    end
                    mode_q = MODE_MOVING;
                end else if (p > center_cfg + deadband_cfg) begin
                    span = max_cfg - center_cfg;
                    if (!rt) begin
                        tgt  = (span > 0) ? round_div((p - center_cfg) * amax, span) : amax;
                        hold = 1'b0;
                    end
                    mode_q = MODE_MOVING;
                end else if (!running) begin
                    mode_q = MODE_IDLE;
                end
                if (tgt > amax) tgt = amax;
                if (tgt < -amax) tgt = -amax;
                // an active switch blocks any motion toward its side
                if (lt && tgt < cur) begin
                    tgt    = cur;
                    hold   = 1'b1;
                    mode_q = MODE_LEFT;
                end
                if (rt && tgt > cur) begin
                    tgt    = cur;
                    hold   = 1'b1;
                    mode_q = MODE_RIGHT;
                end
                if (hold) begin
                    tp = pos_q;
                end else begin
                    tp = round_div(tgt * ppd, one);
                    if (tp > POS_MAX) tp = POS_MAX;
                    if (tp < -POS_MAX) tp = -POS_MAX;
                end
                delta = tp - pos_q;
                tenth = round_div(one, 10);
                ad    = (delta < 0) ? -delta : delta;
                dg    = (tgt > cur) ? tgt - cur : cur - tgt;
                // skip moves that are small both in pulses and in angle
                if (!((ad < SMALL_PULSES && dg < tenth) || delta == 0)) begin
                    pos_q   = tp;
                    r.cmd   = CMD_MOVE;
                    r.delta = delta[DELTA_W-1:0];
                    r.vel   = vel_cfg[VEL_W-1:0];
                end
            end
        endcase
        r.mode = mode_q;
        r.pos  = pos_q[POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errs++;
        // cap the log on a badly broken run
        if (errs <= 200) $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_steer_result want;
        if (!i_rst_n) begin
            center_cfg   = RST_CENTER;
            deadband_cfg = RST_DEADBAND;
            min_cfg      = RST_MIN;
            max_cfg      = RST_MAX;
            angle_cfg    = RST_ANGLE;
            ppd_cfg      = RST_PPD;
            vel_cfg      = RST_VEL;
            pos_q        = 0;
            mode_q       = MODE_IDLE;
            expected_commands.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_CENTER:    center_cfg   = i_cfg_data[CTR_W-1:0];
                    CFG_DEADBAND:  deadband_cfg = i_cfg_data[DB_W-1:0];
                    CFG_MIN_VALID: min_cfg      = i_cfg_data[CTR_W-1:0];
                    CFG_MAX_VALID: max_cfg      = i_cfg_data[CTR_W-1:0];
                    CFG_MAX_ANGLE: angle_cfg    = i_cfg_data[ANG_W-1:0];
                    CFG_PPD:       ppd_cfg      = i_cfg_data[PPD_W-1:0];
                    CFG_VELOCITY:  vel_cfg      = i_cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_commands.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_commands.pop_front();
                    check_field("command", i_out_user, want.cmd);
                    check_field("move_delta", i_out_data[DELTA_W-1:0], want.delta);
                    check_field("velocity", i_out_data[DELTA_W +: VEL_W], want.vel);
                    check_field("steer_mode", i_out_data[DELTA_W+VEL_W +: 2], want.mode);
                    check_field("position", i_out_data[DELTA_W+VEL_W+2 +: POS_W], want.pos);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready)
                expected_commands.push_back(predict_steering(t_op'(i_in_user),
                                                             i_in_data[PW_BITS-1:0],
                                                             i_in_data[PW_BITS],
                                                             i_in_data[PW_BITS+1],
                                                             i_in_data[PW_BITS+2]));
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (expected_commands.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_commands.size()));
            end
        end
        o_pending <= expected_commands.size();
        o_errors  <= errs;
    end

endmodule

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stimulus for the RC steering block: directed pulses, limits, stops and
// register corner cases, then random register phases with mostly in-window
// pulse sequences. Both stream sides idle at random; a checker predicts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rcs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 152;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [TUSER_W-1:0]     s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0]     m_axis_tuser;

    logic end_check;
    int   pending;
    int   errors;
    int   stall_cycles = 0;
    bit   calm;
    int   cur_center, cur_min, cur_max, last_pulse;

    always #5 i_clk = ~i_clk;

    rc_pulse_to_stepper_steering dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    steering_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_end_check (end_check),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else          m_axis_tready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int clip_pulse(input int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    task automatic send_item(input t_op op, input int pulse, input bit lt, input bit rt,
                             input bit running);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[PW_BITS-1:0] = pulse[PW_BITS-1:0];
        word[PW_BITS]     = lt;
        word[PW_BITS+1]   = rt;
        word[PW_BITS+2]   = running;
        if (!calm && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        last_pulse = pulse;
    endtask

    // hold the input side until every expected result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_settings(input int center, input int deadband, input int min_us,
                                 input int max_us, input int angle, input int ppd,
                                 input int velocity);
        write_reg(CFG_CENTER, center);
        write_reg(CFG_DEADBAND, deadband);
        write_reg(CFG_MIN_VALID, min_us);
        write_reg(CFG_MAX_VALID, max_us);
        write_reg(CFG_MAX_ANGLE, angle);
        write_reg(CFG_PPD, ppd);
        write_reg(CFG_VELOCITY, velocity);
        i_cfg_valid <= 1'b0;
        cur_center = center;
        cur_min    = min_us;
        cur_max    = max_us;
    endtask

    task automatic random_settings();
        int c, mn, mx, db, ang, ppd;
        c  = ($urandom_range(99) < 20) ? $urandom_range(4095) : $urandom_range(1200, 1800);
        mn = ($urandom_range(99) < 15) ? $urandom_range(4095)
                                       : clip_pulse(c - $urandom_range(0, 800));
        mx = ($urandom_range(99) < 15) ? $urandom_range(4095)
                                       : clip_pulse(c + $urandom_range(0, 800));
        db = ($urandom_range(99) < 15) ? $urandom_range(255) : $urandom_range(0, 40);
        if ($urandom_range(99) < 20) ang = $urandom_range(1) ? 180 : 1;
        else                         ang = $urandom_range(1, 180);
        if ($urandom_range(99) < 15) ppd = $urandom_range(1) ? 1024 : 1;
        else                         ppd = $urandom_range(1, 300);
        load_settings(c, db, mn, mx, ang, ppd, $urandom_range(65535));
    endtask

    task automatic random_item();
        int r, lo, hi, pulse;
        t_op op;
        r = $urandom_range(99);
        if (r < 4)      op = OP_STOP;
        else if (r < 8) op = OP_LEFT_EDGE;
        else if (r < 12) op = OP_RIGHT_EDGE;
        else            op = OP_PULSE;
        lo = cur_center;
        hi = cur_center;
        if (cur_min < lo) lo = cur_min;
        if (cur_max < lo) lo = cur_max;
        if (cur_min > hi) hi = cur_min;
        if (cur_max > hi) hi = cur_max;
        lo = clip_pulse(lo - 60);
        hi = clip_pulse(hi + 60);
        r = $urandom_range(99);
        if (r < 20)      pulse = $urandom_range(4095);
        else if (r < 45) pulse = clip_pulse(last_pulse + $urandom_range(6) - 3);
        else             pulse = $urandom_range(lo, hi);
        send_item(op, pulse, $urandom_range(99) < 15, $urandom_range(99) < 15,
                  $urandom_range(1));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        end_check     <= 1'b0;
        calm       = 1'b0;
        cur_center = RST_CENTER;
        cur_min    = RST_MIN;
        cur_max    = RST_MAX;
        last_pulse = RST_CENTER;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: window edges, deadband edges, limits, stop and edges
        send_item(OP_PULSE, 1500, 0, 0, 0);
        send_item(OP_PULSE, 1500, 0, 0, 1);
        send_item(OP_PULSE, 4095, 0, 0, 0);
        send_item(OP_PULSE, 2000, 0, 0, 1);
        send_item(OP_PULSE, 1600, 0, 0, 1);
        send_item(OP_PULSE, 1600, 0, 0, 1);
        send_item(OP_PULSE, 1601, 0, 0, 1);
        send_item(OP_PULSE, 1600, 1, 0, 1);
        send_item(OP_PULSE, 1521, 0, 0, 0);
        send_item(OP_PULSE, 1520, 0, 0, 0);
        send_item(OP_PULSE, 1479, 0, 0, 0);
        send_item(OP_PULSE, 1000, 0, 0, 1);
        send_item(OP_PULSE, 0, 1, 0, 0);
        send_item(OP_PULSE, 0, 1, 1, 1);
        send_item(OP_PULSE, 4095, 1, 1, 1);
        send_item(OP_PULSE, 4095, 0, 1, 0);
        send_item(OP_LEFT_EDGE, 0, 1, 0, 1);
        send_item(OP_RIGHT_EDGE, 4095, 0, 1, 0);
        send_item(OP_STOP, 1500, 0, 0, 0);
        drain_results();

        // zero span on the left, negative on the right, pulses per degree zero
        load_settings(1500, 0, 1500, 1000, 180, 0, 65535);
        send_item(OP_PULSE, 0, 0, 0, 0);
        send_item(OP_PULSE, 4095, 0, 0, 0);
        send_item(OP_PULSE, 1499, 0, 0, 1);
        send_item(OP_PULSE, 1501, 0, 0, 1);
        send_item(OP_PULSE, 1500, 0, 0, 0);
        drain_results();

        // center at the bottom: nothing can steer left
        load_settings(0, 255, 0, 4095, 1, 1024, 0);
        send_item(OP_PULSE, 255, 0, 0, 0);
        send_item(OP_PULSE, 256, 0, 0, 0);
        send_item(OP_PULSE, 4095, 0, 0, 1);
        drain_results();

        // center at the top
        load_settings(4095, 255, 0, 4095, 180, 1024, 12345);
        send_item(OP_PULSE, 0, 0, 0, 0);
        send_item(OP_PULSE, 3840, 0, 0, 0);
        send_item(OP_PULSE, 3839, 0, 0, 1);
        send_item(OP_PULSE, 4095, 0, 0, 0);
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_settings();
            calm = (ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if ($urandom_range(99) == 0) drain_results();
            end
            drain_results();
        end
        calm = 1'b0;

        repeat (60) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: rc_pulse_to_stepper_steering.f
+incdir+sv
sv/rcs_pkg.sv
sv/rcs_div.sv
sv/rcs_dp.sv
sv/rcs_ctrl.sv
sv/rc_pulse_to_stepper_steering.sv
tb/sv/steering_checker.sv
tb/sv/testbench.sv
